FILE: design/ttscv_pkg.sv
// Shared types, constants and helper functions for the two-track CV step recorder.
package ttscv_pkg;

    localparam int MAX_STEPS_DEF   = 256;
    localparam int MAX_BANKS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int BANK_W     = 4;
    localparam int BANK_SLOTS = 16;
    localparam int STEP_OUT_W = 9;
    localparam int TIMER_W    = 16;
    localparam int REP_W      = 5;
    localparam int COEF_W     = 17;
    localparam int SEEK_W     = 12;
    localparam int USER_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

    typedef enum logic [3:0] {
        OP_TICK    = 4'd0,
        OP_WRITE   = 4'd1,
        OP_REST    = 4'd2,
        OP_CLEAR   = 4'd3,
        OP_POS_RST = 4'd4,
        OP_NEXT    = 4'd5,
        OP_PREV    = 4'd6,
        OP_BANK_NX = 4'd7,
        OP_BANK_PV = 4'd8,
        OP_BANK_RS = 4'd9,
        OP_TOGGLE  = 4'd10,
        OP_RUN     = 4'd11
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SONG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE     = 3'd7;

    localparam logic [1:0] SONG_A = 2'd1;
    localparam logic [1:0] SONG_B = 2'd2;

    typedef struct packed {
        logic load;
        logic advance;
    } slew_ctrl_t;

    function automatic logic [TIMER_W-1:0] fire(input logic [TIMER_W-1:0] timer,
                                                input logic [TIMER_W-1:0] pulse);
        return (pulse > timer) ? pulse : timer;
    endfunction

    function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b,
                                                   input logic [REP_W-1:0] n);
        logic [REP_W-1:0] nb;
        nb = REP_W'(b) + 5'd1;
        return (nb >= n) ? '0 : BANK_W'(nb);
    endfunction

    function automatic logic [BANK_W-1:0] bank_dec(input logic [BANK_W-1:0] b,
                                                   input logic [REP_W-1:0] n);
        logic [REP_W-1:0] nm;
        nm = n - 5'd1;
        return (b == '0 || REP_W'(b) >= n) ? BANK_W'(nm) : b - 4'd1;
    endfunction

endpackage

FILE: design/ttscv_slew.sv
// One-pole slew filter for one track: registered multiply, then accumulate and round.
module ttscv_slew #(
    parameter int SAMPLE_BITS = ttscv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ttscv_pkg::slew_ctrl_t                ctrl,
    input  logic signed [SAMPLE_BITS-1:0]        target,
    input  logic        [ttscv_pkg::COEF_W-1:0]  coef,
    output logic signed [SAMPLE_BITS-1:0]        cv_next
);

    localparam int ACC_W  = SAMPLE_BITS + 8;
    localparam int DIFF_W = SAMPLE_BITS + 9;
    localparam int PROD_W = DIFF_W + ttscv_pkg::COEF_W + 1;
    localparam int OUT_W  = ACC_W + 1;
    localparam logic signed [OUT_W-1:0] CV_MAX = OUT_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [OUT_W-1:0] CV_MIN = -CV_MAX - OUT_W'(1);

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DIFF_W-1:0] diff;
    logic        [ttscv_pkg::COEF_W-1:0] coef_c;
    logic        [PROD_W-1:0] mag;
    logic        [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] delta;
    logic signed [OUT_W-1:0]  o;

    always_comb
    begin
        coef_c    = (coef > ttscv_pkg::COEF_ONE) ? ttscv_pkg::COEF_ONE : coef;
        diff      = (DIFF_W'(target) <<< 8) - DIFF_W'(acc_reg);
        prod_next = PROD_W'(diff) * $signed({1'b0, coef_c});
        mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        rnd       = (mag + PROD_W'(32768)) >> 16;
        delta     = prod_reg[PROD_W-1] ? -$signed(rnd) : $signed(rnd);
        acc_next  = acc_reg + ACC_W'(delta);
        o         = (OUT_W'(acc_next) + OUT_W'(128)) >>> 8;
        if (o > CV_MAX)
        begin
            cv_next = SAMPLE_BITS'(CV_MAX);
        end
        else if (o < CV_MIN)
        begin
            cv_next = SAMPLE_BITS'(CV_MIN);
        end
        else
        begin
            cv_next = SAMPLE_BITS'(o);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: design/two_track_cv_step_recorder.sv
// Top level of the two-track CV step recorder: event decode, step memory and result stage.
//
//  Channel  | Signals                     | Contents
//  ---------+-----------------------------+-----------------------------------------------
//  input    | s_tvalid s_tready s_tdata   | one event transaction per sample tick
//           | s_tuser                     | opcode and jack flag
//  output   | m_tvalid m_tready m_tdata   | one result transaction per input transaction
//  config   | cfg_we cfg_addr cfg_wdata   | register writes; user must keep to idle (unenforced)
//
// A new input transaction is not taken while the previous one is in s1. When accepted, the
// event updates the playheads and issues the step memory write and both reads; in the s1
// stage the read data selects the CV targets and the slew multiply is registered. The result
// then enters the output register from s2. A stalled output register holds off new input.
// Reset clears all control state and the bank lengths at once; the step memory is not cleared.
module two_track_cv_step_recorder #(
    parameter int MAX_STEPS   = ttscv_pkg::MAX_STEPS_DEF,
    parameter int MAX_BANKS   = ttscv_pkg::MAX_BANKS_DEF,
    parameter int SAMPLE_BITS = ttscv_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + 14 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 32 + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // cv_in, seek_level, seek_connected, run_level
    input  logic [IN_W-1:0]                      s_tdata,
    // opcode, from_jack
    input  logic [ttscv_pkg::USER_W-1:0]         s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cv_out_a, cv_out_b, gate_a, gate_b, end_a, end_b, run_lamp, step_a, step_b,
    // bank_a, bank_b, track_sel
    output logic [OUT_W-1:0]                     m_tdata,
    input  logic                                 cfg_we,
    input  logic [ttscv_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ttscv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int POS_W   = $clog2(MAX_STEPS + 1);
    localparam int STEP_AW = $clog2(MAX_STEPS);
    localparam int ADDR_W  = 1 + ttscv_pkg::BANK_W + STEP_AW;
    localparam int WORD_W  = SAMPLE_BITS + 1;
    localparam int BW      = ttscv_pkg::BANK_W;
    localparam int TW      = ttscv_pkg::TIMER_W;
    localparam int RW      = ttscv_pkg::REP_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STEPS);
    localparam logic [RW-1:0]    BANKS_MAX = RW'(MAX_BANKS);

    // Configuration registers.
    logic [1:0]                    song_mode_reg;
    logic [RW-1:0]                 repeat_target_reg;
    logic [RW-1:0]                 bank_count_reg;
    logic                          bypass_reg;
    logic                          split_reg;
    logic [ttscv_pkg::COEF_W-1:0]  coef_reg [2];
    logic [TW-1:0]                 pulse_reg;

    // Sequencer state.
    logic                          sel_reg;
    logic                          run_reg;
    logic [POS_W-1:0]              pos_reg   [2];
    logic [BW-1:0]                 bank_reg  [2];
    logic signed [SAMPLE_BITS-1:0] lcv_reg   [2];
    logic [TW-1:0]                 trig_reg  [2];
    logic [TW-1:0]                 endt_reg  [2];
    logic [RW-1:0]                 rep_reg   [2];
    logic [POS_W-1:0]              len_reg   [2][ttscv_pkg::BANK_SLOTS];

    // Step memory.
    logic [WORD_W-1:0]             step_mem  [2 ** ADDR_W];
    logic [WORD_W-1:0]             rdata_reg [2];
    logic [WORD_W-1:0]             wdata_reg;
    logic                          fwd_reg   [2];

    // Pipeline.
    logic                          s1_valid_reg;
    logic                          s1_pass_reg;
    logic                          s1_run_reg;
    logic signed [SAMPLE_BITS-1:0] s1_cv_reg;
    logic                          s2_valid_reg;
    logic                          s2_gate_reg [2];
    logic                          s2_end_reg  [2];
    logic                          s2_run_reg;
    logic [POS_W-1:0]              s2_pos_reg  [2];
    logic [BW-1:0]                 s2_bank_reg [2];
    logic                          s2_sel_reg;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    // Input fields.
    ttscv_pkg::opcode_t            op;
    logic                          jack;
    logic signed [SAMPLE_BITS-1:0] cv_in;
    logic [ttscv_pkg::SEEK_W-1:0]  seek_level;
    logic                          seek_conn;
    logic                          run_in;

    // Event decode results.
    logic                          accept;
    logic                          s2_adv;
    logic [RW-1:0]                 n_banks;
    logic                          sel_next;
    logic                          run_next;
    logic                          run_act;
    logic [POS_W-1:0]              pos_next  [2];
    logic [BW-1:0]                 bank_next [2];
    logic signed [SAMPLE_BITS-1:0] lcv_next  [2];
    logic [TW-1:0]                 trig_next [2];
    logic [TW-1:0]                 endt_next [2];
    logic [RW-1:0]                 rep_next  [2];
    logic                          len_we;
    logic [POS_W-1:0]              len_wv;
    logic                          mem_we;
    logic [WORD_W-1:0]             mem_wdata;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [ADDR_W-1:0]             mem_raddr [2];

    // s1 stage results.
    logic signed [SAMPLE_BITS-1:0] target    [2];
    logic                          gate_p1   [2];
    logic                          end_p1    [2];
    logic [TW-1:0]                 trig_p1   [2];
    logic [TW-1:0]                 endt_p1   [2];
    logic signed [SAMPLE_BITS-1:0] cv_next   [2];
    ttscv_pkg::slew_ctrl_t         slew_ctrl;

    assign op         = ttscv_pkg::opcode_t'(s_tuser[3:0]);
    assign jack       = s_tuser[4];
    assign cv_in      = s_tdata[SAMPLE_BITS-1:0];
    assign seek_level = s_tdata[SAMPLE_BITS+11:SAMPLE_BITS];
    assign seek_conn  = s_tdata[SAMPLE_BITS+12];
    assign run_in     = s_tdata[SAMPLE_BITS+13];

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign n_banks = (bank_count_reg == '0) ? RW'(1) :
                     (bank_count_reg > BANKS_MAX) ? BANKS_MAX : bank_count_reg;

    always_comb
    begin
        logic [POS_W-1:0]   cur_len;
        logic [POS_W-1:0]   wr_pos;
        logic [POS_W-1:0]   mem_wpos;
        logic [POS_W-1:0]   slen [2];
        logic [POS_W:0]     p_inc;
        logic [23:0]        z;
        logic [24:0]        q;
        logic [POS_W-1:0]   np;
        logic [RW-1:0]      ctr;
        logic               seeking;
        logic               do_next [2];
        logic               do_prev [2];
        logic               end_seen [2];
        logic               advanced;
        logic               put_ok;

        sel_next  = sel_reg ^ (op == ttscv_pkg::OP_TOGGLE);
        run_next  = run_reg;
        pos_next  = pos_reg;
        bank_next = bank_reg;
        lcv_next  = lcv_reg;
        trig_next = trig_reg;
        endt_next = endt_reg;
        rep_next  = rep_reg;
        len_we    = 1'b0;
        len_wv    = '0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_wpos  = '0;
        put_ok    = 1'b0;
        advanced  = 1'b0;
        p_inc     = '0;
        z         = '0;
        q         = '0;
        np        = '0;
        ctr       = '0;
        for (int i = 0; i < 2; i++)
        begin
            do_next[i]  = 1'b0;
            do_prev[i]  = 1'b0;
            end_seen[i] = 1'b0;
        end
        cur_len = len_reg[sel_next][bank_reg[sel_next]];
        wr_pos  = pos_reg[sel_next];

        case (op)
            ttscv_pkg::OP_WRITE, ttscv_pkg::OP_REST:
            begin
                if (wr_pos < cur_len)
                begin
                    mem_wpos = wr_pos;
                    put_ok   = 1'b1;
                end
                else if (cur_len < POS_MAX)
                begin
                    mem_wpos = cur_len;
                    len_we   = 1'b1;
                    len_wv   = cur_len + POS_W'(1);
                    put_ok   = 1'b1;
                end
                if (put_ok)
                begin
                    mem_we = 1'b1;
                    pos_next[sel_next] = (wr_pos < POS_MAX) ? wr_pos + POS_W'(1) : POS_MAX;
                    if (op == ttscv_pkg::OP_WRITE)
                    begin
                        mem_wdata           = {1'b0, cv_in};
                        lcv_next[sel_next]  = cv_in;
                        trig_next[sel_next] = ttscv_pkg::fire(trig_reg[sel_next], pulse_reg);
                    end
                    else
                    begin
                        mem_wdata = {1'b1, {SAMPLE_BITS{1'b0}}};
                    end
                end
            end
            ttscv_pkg::OP_CLEAR:
            begin
                len_we             = 1'b1;
                len_wv             = '0;
                pos_next[sel_next] = '0;
                run_next           = 1'b0;
            end
            ttscv_pkg::OP_POS_RST:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    pos_next[i]  = '0;
                    endt_next[i] = ttscv_pkg::fire(endt_reg[i], pulse_reg);
                end
            end
            ttscv_pkg::OP_BANK_NX, ttscv_pkg::OP_BANK_PV, ttscv_pkg::OP_BANK_RS:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (op == ttscv_pkg::OP_BANK_RS || !(jack && split_reg) ||
                        (op == ttscv_pkg::OP_BANK_NX) == (i == 0))
                    begin
                        if (op == ttscv_pkg::OP_BANK_RS)
                        begin
                            bank_next[i] = '0;
                        end
                        else if (op == ttscv_pkg::OP_BANK_NX || (jack && split_reg))
                        begin
                            bank_next[i] = ttscv_pkg::bank_inc(bank_reg[i], n_banks);
                        end
                        else
                        begin
                            bank_next[i] = ttscv_pkg::bank_dec(bank_reg[i], n_banks);
                        end
                        pos_next[i]  = '0;
                        trig_next[i] = ttscv_pkg::fire(trig_reg[i], pulse_reg);
                        rep_next[0]  = '0;
                        rep_next[1]  = '0;
                    end
                end
            end
            ttscv_pkg::OP_RUN:
            begin
                run_next = !run_reg;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase

        run_act = run_next || run_in;
        seeking = seek_conn && (seek_level != '0) && run_act;

        for (int i = 0; i < 2; i++)
        begin
            slen[i] = (len_we && sel_next == 1'(i)) ? len_wv : len_reg[i][bank_next[i]];
        end

        if (!seeking && (op == ttscv_pkg::OP_NEXT || op == ttscv_pkg::OP_PREV) &&
            (!jack || run_act))
        begin
            if (jack && split_reg)
            begin
                do_next[0] = (op == ttscv_pkg::OP_NEXT);
                do_next[1] = (op == ttscv_pkg::OP_PREV);
            end
            else
            begin
                for (int i = 0; i < 2; i++)
                begin
                    do_next[i] = (op == ttscv_pkg::OP_NEXT);
                    do_prev[i] = (op == ttscv_pkg::OP_PREV);
                end
            end
        end

        for (int i = 0; i < 2; i++)
        begin
            if (slen[i] != '0)
            begin
                if (do_next[i])
                begin
                    p_inc        = {1'b0, pos_next[i]} + (POS_W + 1)'(1);
                    trig_next[i] = ttscv_pkg::fire(trig_next[i], pulse_reg);
                    if (p_inc >= {1'b0, slen[i]})
                    begin
                        p_inc        = '0;
                        endt_next[i] = ttscv_pkg::fire(endt_next[i], pulse_reg);
                        end_seen[i]  = 1'b1;
                    end
                    pos_next[i] = POS_W'(p_inc);
                end
                else if (do_prev[i])
                begin
                    pos_next[i]  = (pos_next[i] == '0) ? slen[i] - POS_W'(1)
                                                      : pos_next[i] - POS_W'(1);
                    trig_next[i] = ttscv_pkg::fire(trig_next[i], pulse_reg);
                end
                if (seeking)
                begin
                    z  = 24'(seek_level) * 24'(slen[i] - POS_W'(1)) + 24'd2047;
                    q  = (25'(z) + 25'(z >> 12) + 25'd1) >> 12;
                    np = POS_W'(q);
                    if (np != pos_next[i])
                    begin
                        pos_next[i]  = np;
                        trig_next[i] = ttscv_pkg::fire(trig_next[i], pulse_reg);
                    end
                end
            end
        end

        for (int i = 0; i < 2; i++)
        begin
            if (end_seen[i] && !advanced &&
                ((song_mode_reg == ttscv_pkg::SONG_A && i == 0) ||
                 (song_mode_reg == ttscv_pkg::SONG_B && i == 1)))
            begin
                ctr         = (rep_next[i] < RW'(31)) ? rep_next[i] + RW'(1) : rep_next[i];
                rep_next[i] = ctr;
                if (ctr >= repeat_target_reg)
                begin
                    advanced = 1'b1;
                    for (int k = 0; k < 2; k++)
                    begin
                        rep_next[k]  = '0;
                        bank_next[k] = ttscv_pkg::bank_inc(bank_next[k], n_banks);
                        pos_next[k]  = '0;
                        trig_next[k] = ttscv_pkg::fire(trig_next[k], pulse_reg);
                    end
                end
            end
        end

        mem_waddr = {sel_next, bank_reg[sel_next], mem_wpos[STEP_AW-1:0]};
        for (int i = 0; i < 2; i++)
        begin
            mem_raddr[i] = {1'(i), bank_next[i], pos_next[i][STEP_AW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            step_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            wdata_reg <= mem_wdata;
            for (int i = 0; i < 2; i++)
            begin
                rdata_reg[i] <= step_mem[mem_raddr[i]];
                fwd_reg[i]   <= mem_we && (mem_raddr[i] == mem_waddr);
            end
        end
    end

    always_comb
    begin
        logic [WORD_W-1:0] w;
        logic              in_bank;
        for (int i = 0; i < 2; i++)
        begin
            w       = fwd_reg[i] ? wdata_reg : rdata_reg[i];
            in_bank = pos_reg[i] < len_reg[i][bank_reg[i]];
            trig_p1[i] = trig_reg[i];
            endt_p1[i] = endt_reg[i];
            if (s1_pass_reg && sel_reg == 1'(i))
            begin
                target[i]  = s1_cv_reg;
                gate_p1[i] = 1'b1;
                end_p1[i]  = 1'b0;
            end
            else
            begin
                if (!in_bank)
                begin
                    target[i] = '0;
                end
                else if (w[SAMPLE_BITS])
                begin
                    target[i]  = lcv_reg[i];
                    trig_p1[i] = '0;
                end
                else
                begin
                    target[i] = w[SAMPLE_BITS-1:0];
                end
                gate_p1[i] = (trig_p1[i] != '0);
                end_p1[i]  = (endt_p1[i] != '0);
                if (trig_p1[i] != '0)
                begin
                    trig_p1[i] = trig_p1[i] - TW'(1);
                end
                if (endt_p1[i] != '0)
                begin
                    endt_p1[i] = endt_p1[i] - TW'(1);
                end
            end
        end
    end

    assign slew_ctrl.load    = s1_valid_reg;
    assign slew_ctrl.advance = s2_adv;

    for (genvar g = 0; g < 2; g++)
    begin : g_slew
        ttscv_slew #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_slew (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (slew_ctrl),
            .target  (target[g]),
            .coef    (coef_reg[g]),
            .cv_next (cv_next[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_mode_reg     <= '0;
            repeat_target_reg <= RW'(1);
            bank_count_reg    <= RW'(1);
            bypass_reg        <= 1'b0;
            split_reg         <= 1'b0;
            coef_reg[0]       <= ttscv_pkg::COEF_ONE;
            coef_reg[1]       <= ttscv_pkg::COEF_ONE;
            pulse_reg         <= TW'(48);
            sel_reg           <= 1'b0;
            run_reg           <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                pos_reg[i]  <= '0;
                bank_reg[i] <= '0;
                lcv_reg[i]  <= '0;
                trig_reg[i] <= '0;
                endt_reg[i] <= '0;
                rep_reg[i]  <= '0;
                for (int b = 0; b < ttscv_pkg::BANK_SLOTS; b++)
                begin
                    len_reg[i][b] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ttscv_pkg::CFG_SONG_MODE: song_mode_reg     <= cfg_wdata[1:0];
                ttscv_pkg::CFG_REPEAT:    repeat_target_reg <= cfg_wdata[RW-1:0];
                ttscv_pkg::CFG_BANKS:
                begin
                    logic [RW-1:0] nb;
                    nb = (cfg_wdata[RW-1:0] == '0) ? RW'(1) :
                         (cfg_wdata[RW-1:0] > BANKS_MAX) ? BANKS_MAX : cfg_wdata[RW-1:0];
                    bank_count_reg <= cfg_wdata[RW-1:0];
                    for (int i = 0; i < 2; i++)
                    begin
                        for (int b = 0; b < ttscv_pkg::BANK_SLOTS; b++)
                        begin
                            if (RW'(b) >= nb)
                            begin
                                len_reg[i][b] <= '0;
                            end
                        end
                        if (RW'(bank_reg[i]) >= nb)
                        begin
                            bank_reg[i] <= BW'(nb - RW'(1));
                        end
                    end
                end
                ttscv_pkg::CFG_BYPASS:    bypass_reg  <= cfg_wdata[0];
                ttscv_pkg::CFG_SPLIT:     split_reg   <= cfg_wdata[0];
                ttscv_pkg::CFG_COEF_A:    coef_reg[0] <= cfg_wdata;
                ttscv_pkg::CFG_COEF_B:    coef_reg[1] <= cfg_wdata;
                ttscv_pkg::CFG_PULSE:     pulse_reg   <= cfg_wdata[TW-1:0];
                default:                  pulse_reg   <= pulse_reg;
            endcase
        end
        else if (accept)
        begin
            sel_reg   <= sel_next;
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            bank_reg  <= bank_next;
            lcv_reg   <= lcv_next;
            trig_reg  <= trig_next;
            endt_reg  <= endt_next;
            rep_reg   <= rep_next;
            if (len_we)
            begin
                len_reg[sel_next][bank_reg[sel_next]] <= len_wv;
            end
        end
        else if (s1_valid_reg)
        begin
            trig_reg <= trig_p1;
            endt_reg <= endt_p1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pass_reg <= bypass_reg && !run_act;
            s1_run_reg  <= run_act;
            s1_cv_reg   <= cv_in;
        end
        if (s1_valid_reg)
        begin
            s2_gate_reg <= gate_p1;
            s2_end_reg  <= end_p1;
            s2_run_reg  <= s1_run_reg;
            s2_pos_reg  <= pos_reg;
            s2_bank_reg <= bank_reg;
            s2_sel_reg  <= sel_reg;
        end
        if (s2_adv)
        begin
            out_data_reg <= OUT_W'({s2_sel_reg, s2_bank_reg[1], s2_bank_reg[0],
                                    ttscv_pkg::STEP_OUT_W'(s2_pos_reg[1]),
                                    ttscv_pkg::STEP_OUT_W'(s2_pos_reg[0]),
                                    s2_run_reg, s2_end_reg[1], s2_end_reg[0],
                                    s2_gate_reg[1], s2_gate_reg[0],
                                    cv_next[1], cv_next[0]});
        end
    end

endmodule

FILE: tb/two_track_cv_step_recorder_test.sv
// Self-checking testbench for the two-track CV step recorder, with a scoreboard and a predictor.
`timescale 1ns / 1ps

module two_track_cv_step_recorder_test;

    typedef struct packed {
        logic        track_sel;
        logic [3:0]  bank_b;
        logic [3:0]  bank_a;
        logic [8:0]  step_b;
        logic [8:0]  step_a;
        logic        run_lamp;
        logic        end_b;
        logic        end_a;
        logic        gate_b;
        logic        gate_a;
        logic [15:0] cv_b;
        logic [15:0] cv_a;
    } tick_result_t;

    class step_recorder_scoreboard;
        logic [16:0]  steps [2*16*256];
        int unsigned  lengths [32];
        int unsigned  pos [2];
        int unsigned  bank [2];
        int           last_cv [2];
        longint       acc [2];
        int unsigned  trig [2];
        int unsigned  endt [2];
        bit           end_flag [2];
        int unsigned  reps [2];
        int unsigned  sel;
        bit           running;
        int unsigned  song, rep_target, nbanks, bypass, split, pulse;
        int unsigned  coef [2];
        tick_result_t expected_results [$];
        int           errors;

        function new();
            foreach (steps[i]) steps[i] = '0;
            foreach (lengths[i]) lengths[i] = 0;
            for (int t = 0; t < 2; t++)
            begin
                pos[t] = 0; bank[t] = 0; last_cv[t] = 0; acc[t] = 0;
                trig[t] = 0; endt[t] = 0; end_flag[t] = 0; reps[t] = 0;
                coef[t] = 65536;
            end
            sel = 0; running = 0;
            song = 0; rep_target = 1; nbanks = 1; bypass = 0; split = 0; pulse = 48;
            errors = 0;
        endfunction

        function int unsigned live_banks();
            if (nbanks < 1) return 1;
            if (nbanks > 16) return 16;
            return nbanks;
        endfunction

        function int unsigned slot(int unsigned t);
            return t * 16 + bank[t];
        endfunction

        function void fire_trig(int unsigned t);
            if (pulse > trig[t]) trig[t] = pulse;
        endfunction

        function void fire_end(int unsigned t);
            if (pulse > endt[t]) endt[t] = pulse;
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] val);
            int unsigned n;
            case (idx)
                ttscv_pkg::CFG_SONG_MODE: song = val[1:0];
                ttscv_pkg::CFG_REPEAT:    rep_target = val[4:0];
                ttscv_pkg::CFG_BANKS:
                begin
                    nbanks = val[4:0];
                    n = live_banks();
                    for (int t = 0; t < 2; t++)
                    begin
                        for (int b = n; b < 16; b++) lengths[t*16+b] = 0;
                        if (bank[t] >= n) bank[t] = n - 1;
                    end
                end
                ttscv_pkg::CFG_BYPASS:    bypass = val[0];
                ttscv_pkg::CFG_SPLIT:     split = val[0];
                ttscv_pkg::CFG_COEF_A:    coef[0] = val;
                ttscv_pkg::CFG_COEF_B:    coef[1] = val;
                ttscv_pkg::CFG_PULSE:     pulse = val[15:0];
                default: ;
            endcase
        endfunction

        function bit record_step(int unsigned t, logic [16:0] word);
            int unsigned s, len, p;
            s = slot(t);
            len = lengths[s];
            p = pos[t];
            if (p < len && p < 256)
                steps[s*256+p] = word;
            else if (len < 256)
            begin
                steps[s*256+len] = word;
                lengths[s] = len + 1;
            end
            else
                return 0;
            pos[t] = (p < 256) ? p + 1 : 256;
            return 1;
        endfunction

        function void advance_step(int unsigned t);
            int unsigned len;
            len = lengths[slot(t)];
            if (len == 0) return;
            pos[t]++;
            fire_trig(t);
            if (pos[t] >= len)
            begin
                pos[t] = 0;
                fire_end(t);
                end_flag[t] = 1;
            end
        endfunction

        function void retreat_step(int unsigned t);
            int unsigned len;
            len = lengths[slot(t)];
            if (len == 0) return;
            if (pos[t] == 0) pos[t] = len - 1;
            else pos[t]--;
            fire_trig(t);
        endfunction

        function void next_bank(int unsigned t);
            bank[t]++;
            if (bank[t] >= live_banks()) bank[t] = 0;
            pos[t] = 0;
            fire_trig(t);
            reps[0] = 0; reps[1] = 0;
        endfunction

        function void prev_bank(int unsigned t);
            if (bank[t] == 0 || bank[t] >= live_banks()) bank[t] = live_banks() - 1;
            else bank[t]--;
            pos[t] = 0;
            fire_trig(t);
            reps[0] = 0; reps[1] = 0;
        endfunction

        function longint round_q16(longint x);
            if (x >= 0) return (x + 32768) >>> 16;
            return -((-x + 32768) >>> 16);
        endfunction

        function void note_event(logic [3:0] op, logic jack, logic signed [15:0] cv,
                                 logic [11:0] seek, logic seek_conn, logic run_in);
            int unsigned t, len, s, c;
            longint np, o;
            bit run_active, seeking, advanced, pass;
            int target;
            logic [16:0] w;
            tick_result_t r;

            if (op == ttscv_pkg::OP_TOGGLE) sel ^= 1;
            t = sel;
            case (op)
                ttscv_pkg::OP_WRITE:
                    if (record_step(t, {1'b0, cv}))
                    begin
                        last_cv[t] = cv;
                        fire_trig(t);
                    end
                ttscv_pkg::OP_REST: void'(record_step(t, 17'h10000));
                ttscv_pkg::OP_CLEAR:
                begin
                    lengths[slot(t)] = 0;
                    pos[t] = 0;
                    running = 0;
                end
                ttscv_pkg::OP_POS_RST:
                    for (int i = 0; i < 2; i++)
                    begin
                        pos[i] = 0;
                        fire_end(i);
                    end
                ttscv_pkg::OP_BANK_NX:
                    if (jack && split) next_bank(0);
                    else
                    begin
                        next_bank(0);
                        next_bank(1);
                    end
                ttscv_pkg::OP_BANK_PV:
                    if (jack && split) next_bank(1);
                    else
                    begin
                        prev_bank(0);
                        prev_bank(1);
                    end
                ttscv_pkg::OP_BANK_RS:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        bank[i] = 0;
                        pos[i] = 0;
                        fire_trig(i);
                    end
                    reps[0] = 0; reps[1] = 0;
                end
                ttscv_pkg::OP_RUN: running = !running;
                default: ;
            endcase

            run_active = running || run_in;
            seeking = seek_conn && seek != 0 && run_active;

            if (!seeking && (op == ttscv_pkg::OP_NEXT || op == ttscv_pkg::OP_PREV) &&
                (!jack || run_active))
            begin
                if (jack && split)
                    advance_step(op == ttscv_pkg::OP_NEXT ? 0 : 1);
                else if (op == ttscv_pkg::OP_NEXT)
                begin
                    advance_step(0);
                    advance_step(1);
                end
                else
                begin
                    retreat_step(0);
                    retreat_step(1);
                end
            end

            if (seeking)
                for (int i = 0; i < 2; i++)
                begin
                    len = lengths[slot(i)];
                    if (len != 0)
                    begin
                        np = (longint'(seek) * (len - 1) * 2 + 4095) / 8190;
                        if (np != pos[i])
                        begin
                            pos[i] = 32'(np);
                            fire_trig(i);
                        end
                    end
                end

            advanced = 0;
            for (int i = 0; i < 2; i++)
            begin
                if (end_flag[i])
                begin
                    end_flag[i] = 0;
                    if (!advanced && ((song == 1 && i == 0) || (song == 2 && i == 1)))
                    begin
                        if (reps[i] < 31) reps[i]++;
                        if (reps[i] >= rep_target)
                        begin
                            reps[0] = 0; reps[1] = 0;
                            next_bank(0);
                            next_bank(1);
                            advanced = 1;
                        end
                    end
                end
            end

            pass = bypass && !run_active;
            for (int i = 0; i < 2; i++)
            begin
                bit g, e;
                if (pass && i == t)
                begin
                    target = cv;
                    g = 1;
                    e = 0;
                end
                else
                begin
                    s = slot(i);
                    len = lengths[s];
                    if (pos[i] < len && pos[i] < 256)
                    begin
                        w = steps[s*256+pos[i]];
                        if (w[16])
                        begin
                            target = last_cv[i];
                            trig[i] = 0;
                        end
                        else
                            target = $signed(w[15:0]);
                    end
                    else
                        target = 0;
                    g = trig[i] != 0;
                    if (trig[i] != 0) trig[i]--;
                    e = endt[i] != 0;
                    if (endt[i] != 0) endt[i]--;
                end
                c = (coef[i] > 65536) ? 65536 : coef[i];
                acc[i] += round_q16((longint'(target) * 256 - acc[i]) * longint'(c));
                o = acc[i] + 128;
                o = (o >= 0) ? (o >>> 8) : -((-o + 255) >>> 8);
                if (o > 32767) o = 32767;
                if (o < -32768) o = -32768;
                if (i == 0)
                begin
                    r.cv_a = o[15:0]; r.gate_a = g; r.end_a = e;
                end
                else
                begin
                    r.cv_b = o[15:0]; r.gate_b = g; r.end_b = e;
                end
            end
            r.run_lamp = run_active;
            r.step_a = pos[0][8:0];
            r.step_b = pos[1][8:0];
            r.bank_a = bank[0][3:0];
            r.bank_b = bank[1][3:0];
            r.track_sel = sel[0];
            expected_results = {expected_results, r};
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(logic [63:0] bits);
            tick_result_t got, want;
            got = bits;
            if (expected_results.size() == 0)
            begin
                report("result transaction with no outstanding input");
                return;
            end
            want = expected_results.pop_front();
            compare_field("cv_out_a", got.cv_a, want.cv_a);
            compare_field("cv_out_b", got.cv_b, want.cv_b);
            compare_field("gate_a", 16'(got.gate_a), 16'(want.gate_a));
            compare_field("gate_b", 16'(got.gate_b), 16'(want.gate_b));
            compare_field("end_a", 16'(got.end_a), 16'(want.end_a));
            compare_field("end_b", 16'(got.end_b), 16'(want.end_b));
            compare_field("run_lamp", 16'(got.run_lamp), 16'(want.run_lamp));
            compare_field("step_a", 16'(got.step_a), 16'(want.step_a));
            compare_field("step_b", 16'(got.step_b), 16'(want.step_b));
            compare_field("bank_a", 16'(got.bank_a), 16'(want.bank_a));
            compare_field("bank_b", 16'(got.bank_b), 16'(want.bank_b));
            compare_field("track_sel", 16'(got.track_sel), 16'(want.track_sel));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = '0;
    logic [16:0] cfg_wdata = '0;

    step_recorder_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    two_track_cv_step_recorder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task send_event(logic [3:0] op, logic jack, logic [15:0] cv, logic [11:0] seek,
                    logic seek_conn, logic run_in);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {jack, op};
        s_tdata <= {2'b00, run_in, seek_conn, seek, cv};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(op, jack, cv, seek, seek_conn, run_in);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task cfg_write(logic [2:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task cfg_finish();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task random_event(int writes_pct);
        logic [3:0] op;
        int k;
        logic [11:0] seek;
        logic sc;
        k = $urandom_range(99);
        if (k < writes_pct) op = ttscv_pkg::OP_WRITE;
        else if (k < writes_pct + 6) op = ttscv_pkg::OP_REST;
        else if (k < writes_pct + 8) op = ttscv_pkg::OP_CLEAR;
        else if (k < writes_pct + 10) op = ttscv_pkg::OP_POS_RST;
        else if (k < writes_pct + 35)
            op = ($urandom_range(2) != 0) ? ttscv_pkg::OP_NEXT : ttscv_pkg::OP_PREV;
        else if (k < writes_pct + 42)
            op = 4'($urandom_range(ttscv_pkg::OP_BANK_NX, ttscv_pkg::OP_BANK_RS));
        else if (k < writes_pct + 45) op = ttscv_pkg::OP_TOGGLE;
        else if (k < writes_pct + 48) op = ttscv_pkg::OP_RUN;
        else if (k < writes_pct + 50) op = 4'($urandom_range(12, 15));
        else op = ttscv_pkg::OP_TICK;
        sc = ($urandom_range(9) == 0);
        seek = ($urandom_range(3) == 0) ? 12'($urandom) : 12'd0;
        send_event(op, 1'($urandom_range(1)), 16'($urandom), seek, sc,
                   $urandom_range(5) == 0);
    endtask

    initial
    begin
        #2000000;
        $display("two_track_cv_step_recorder: mismatch");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(ttscv_pkg::OP_TICK, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_NEXT, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_WRITE, 1, 16'h7FFF, 0, 0, 0);
        send_event(ttscv_pkg::OP_WRITE, 0, 16'h8000, 12'hFFF, 1, 0);
        send_event(ttscv_pkg::OP_REST, 0, 16'h1234, 0, 0, 0);
        send_event(ttscv_pkg::OP_WRITE, 0, 16'hFFFF, 0, 0, 0);
        send_event(ttscv_pkg::OP_NEXT, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_PREV, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_NEXT, 1, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_NEXT, 1, 16'h0000, 0, 0, 1);
        send_event(ttscv_pkg::OP_PREV, 1, 16'h0000, 0, 0, 1);
        send_event(ttscv_pkg::OP_RUN, 1, 16'h0000, 12'hFFF, 1, 0);
        send_event(ttscv_pkg::OP_TICK, 0, 16'h0000, 12'd1, 1, 0);
        send_event(ttscv_pkg::OP_NEXT, 0, 16'h0000, 12'd2048, 1, 0);
        send_event(ttscv_pkg::OP_POS_RST, 1, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_BANK_NX, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_BANK_PV, 1, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_BANK_RS, 1, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_TOGGLE, 1, 16'h5555, 0, 0, 0);
        send_event(ttscv_pkg::OP_WRITE, 0, 16'hAAAA, 0, 0, 0);
        send_event(4'd12, 1, 16'h0000, 0, 0, 0);
        send_event(4'd15, 0, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_CLEAR, 1, 16'h0000, 0, 0, 0);
        send_event(ttscv_pkg::OP_RUN, 0, 16'h0000, 0, 0, 0);
        drain();

        cfg_write(ttscv_pkg::CFG_SONG_MODE, 17'd1);
        cfg_write(ttscv_pkg::CFG_REPEAT, 17'd2);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd4);
        cfg_write(ttscv_pkg::CFG_BYPASS, 17'd1);
        cfg_write(ttscv_pkg::CFG_SPLIT, 17'd1);
        cfg_write(ttscv_pkg::CFG_COEF_A, 17'($urandom_range(65536)));
        cfg_write(ttscv_pkg::CFG_COEF_B, 17'($urandom_range(65536)));
        cfg_write(ttscv_pkg::CFG_PULSE, 17'd3);
        cfg_finish();
        send_idle_pct = 54;
        repeat (200) random_event(25);
        drain();

        cfg_write(ttscv_pkg::CFG_SONG_MODE, 17'd2);
        cfg_write(ttscv_pkg::CFG_REPEAT, 17'd0);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd16);
        cfg_write(ttscv_pkg::CFG_BYPASS, 17'd0);
        cfg_write(ttscv_pkg::CFG_SPLIT, 17'd0);
        cfg_write(ttscv_pkg::CFG_COEF_A, 17'd0);
        cfg_write(ttscv_pkg::CFG_COEF_B, 17'h1FFFF);
        cfg_write(ttscv_pkg::CFG_PULSE, 17'd65535);
        cfg_finish();
        send_idle_pct = 0;
        recv_stall_pct = 54;
        repeat (100) random_event(25);
        hold_request = 300;
        repeat (100) random_event(25);
        drain();

        cfg_write(ttscv_pkg::CFG_SONG_MODE, 17'd0);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd1);
        cfg_write(ttscv_pkg::CFG_PULSE, 17'd1);
        cfg_write(ttscv_pkg::CFG_COEF_A, 17'd65536);
        cfg_finish();
        send_idle_pct = 15;
        recv_stall_pct = 15;
        send_event(ttscv_pkg::OP_CLEAR, 0, 16'h0000, 0, 0, 0);
        for (int i = 0; i < 275; i++)
            send_event(($urandom_range(7) == 0) ? ttscv_pkg::OP_REST : ttscv_pkg::OP_WRITE,
                       1'($urandom_range(1)), 16'($urandom), 0, 0, 0);
        repeat (10) random_event(10);
        drain();

        cfg_write(ttscv_pkg::CFG_SONG_MODE, 17'd3);
        cfg_write(ttscv_pkg::CFG_REPEAT, 17'd31);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd20);
        cfg_write(ttscv_pkg::CFG_PULSE, 17'd0);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd0);
        cfg_finish();
        repeat (200) random_event(30);
        drain();

        cfg_write(ttscv_pkg::CFG_SONG_MODE, 17'd1);
        cfg_write(ttscv_pkg::CFG_REPEAT, 17'd16);
        cfg_write(ttscv_pkg::CFG_BANKS, 17'd3);
        cfg_write(ttscv_pkg::CFG_PULSE, 17'd48);
        cfg_write(ttscv_pkg::CFG_SPLIT, 17'd1);
        cfg_write(ttscv_pkg::CFG_COEF_B, 17'd40000);
        cfg_finish();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (120) random_event(30);
        drain();
        repeat (120) random_event(20);
        drain();
        repeat (30) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("two_track_cv_step_recorder: match");
        else
            $display("two_track_cv_step_recorder: mismatch");
        $finish;
    end
endmodule
